// ===== src/rafp_pkg.sv =====
`default_nettype none

package rafp_pkg;

   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] END_BYTE   = 8'h03;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] LF_BYTE    = 8'h0A;

   localparam int CHARS_PER_FRAME = 12;
   localparam int TAG_BYTES       = 5;
   localparam int TAG_WIDTH       = TAG_BYTES * 8;
   localparam int COUNT_WIDTH     = 4;
   localparam int BYTE_IDX_WIDTH  = $clog2(TAG_BYTES);

   localparam logic [COUNT_WIDTH-1:0] LAST_CHAR_INDEX = COUNT_WIDTH'(CHARS_PER_FRAME - 1);

   // one received character after decode
   typedef struct packed {
      logic       is_start;
      logic       is_term;
      logic [7:0] nibble;
   } decoded_char_type;

   // frame tracking state seen by the top level
   typedef struct packed {
      logic                   in_frame;
      logic [COUNT_WIDTH-1:0] char_count;
      logic                   emit;
      logic                   take;
   } frame_status_type;

endpackage

`default_nettype wire

// ===== src/rfid_ascii_frame_parser.sv =====
// result path: a frame's last character is registered on transfer, and its result
//   is then registered into the result register that drives rsp_valid
// throughput: one byte per cycle; the single result register stalls the input
//   only when a finished tag is still waiting and the next byte completes a frame
// reset (synchronous, active high) returns the parser to idle with no result held
`default_nettype none

module rfid_ascii_frame_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [rafp_pkg::TAG_WIDTH-1:0]       rsp_tag_id,
   output logic                                 rsp_checksum_ok
);

   rafp_pkg::decoded_char_type decoded;
   rafp_pkg::decoded_char_type char_ff;
   rafp_pkg::frame_status_type status;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       accept;

   rafp_decode u_decode (
      .rx_byte  (req_rx_byte),
      .char_out (decoded)
   );

   assign req_stall = s1_valid_ff && !status.take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (status.take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= decoded;
      end
   end

   rafp_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .char_valid      (s1_valid_ff),
      .char_in         (char_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_tag_id      (rsp_tag_id),
      .rsp_checksum_ok (rsp_checksum_ok),
      .status          (status)
   );

   // a completed frame always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      (status.take && status.emit) |=> rsp_valid)
      else $error("completed frame did not raise rsp_valid");

   // idle parser keeps a cleared character count
   assert property (@(posedge clock) disable iff (reset)
      !status.in_frame |-> (status.char_count == '0))
      else $error("character count nonzero while idle");

   // input stalls only when a finished tag blocks the result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && status.emit && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // a frame never runs past its last character
   assert property (@(posedge clock) disable iff (reset)
      (status.char_count == rafp_pkg::LAST_CHAR_INDEX && status.take && status.in_frame)
      |=> (status.char_count == '0))
      else $error("character count ran past end of frame");

endmodule

`default_nettype wire

// ===== src/rafp_decode.sv =====
`default_nettype none

module rafp_decode (
   input  wire logic [7:0]                 rx_byte,
   output rafp_pkg::decoded_char_type      char_out
);

   always_comb begin
      char_out.is_start = (rx_byte == rafp_pkg::START_BYTE);
      char_out.is_term  = (rx_byte == rafp_pkg::START_BYTE) || (rx_byte == rafp_pkg::END_BYTE)
                          || (rx_byte == rafp_pkg::CR_BYTE) || (rx_byte == rafp_pkg::LF_BYTE);
      case (1'b1)
         (rx_byte inside {[8'h30:8'h39]}): char_out.nibble = rx_byte - 8'h30;
         (rx_byte inside {[8'h41:8'h46]}): char_out.nibble = rx_byte - 8'h37;
         // non-hex characters pass through with their raw value
         default:                          char_out.nibble = rx_byte;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/rafp_frame.sv =====
`default_nettype none

module rafp_frame (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                char_valid,
   input  wire rafp_pkg::decoded_char_type          char_in,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic [rafp_pkg::TAG_WIDTH-1:0]           rsp_tag_id,
   output logic                                     rsp_checksum_ok,
   output rafp_pkg::frame_status_type               status
);

   logic                                in_frame_ff, in_frame_in;
   logic [rafp_pkg::COUNT_WIDTH-1:0]    char_count_ff, char_count_in;
   logic [7:0]                          hold_ff, hold_in;
   logic [7:0]                          bytes_ff [rafp_pkg::TAG_BYTES];
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rafp_pkg::TAG_WIDTH-1:0]      tag_ff;
   logic                                ok_ff;

   logic                                emit;
   logic                                take;
   logic                                write_byte;
   logic [7:0]                          pair_byte;
   logic [rafp_pkg::BYTE_IDX_WIDTH-1:0] byte_idx;
   logic [rafp_pkg::TAG_WIDTH-1:0]      tag_word;
   logic [7:0]                          xor_sum;

   // the raw character value is or-ed in whole, high bits included
   assign pair_byte = {hold_ff[3:0], 4'b0000} | char_in.nibble;
   assign byte_idx  = char_count_ff[rafp_pkg::BYTE_IDX_WIDTH:1];

   assign emit = in_frame_ff && !char_in.is_term && (char_count_ff == rafp_pkg::LAST_CHAR_INDEX);
   assign take = char_valid && (!emit || !rsp_valid_ff || !rsp_stall);
   assign write_byte = take && in_frame_ff && !char_in.is_term && char_count_ff[0] && !emit;

   always_comb begin
      tag_word = '0;
      xor_sum  = '0;
      for (int i = 0; i < rafp_pkg::TAG_BYTES; i++) begin
         tag_word = {tag_word[rafp_pkg::TAG_WIDTH-9:0], bytes_ff[i]};
         xor_sum  = xor_sum ^ bytes_ff[i];
      end
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      char_count_in = char_count_ff;
      hold_in       = hold_ff;
      if (take) begin
         if (!in_frame_ff) begin
            if (char_in.is_start) begin
               in_frame_in   = 1'b1;
               char_count_in = '0;
            end
         end else if (char_in.is_term || emit) begin
            in_frame_in   = 1'b0;
            char_count_in = '0;
         end else begin
            if (!char_count_ff[0]) begin
               hold_in = char_in.nibble;
            end
            char_count_in = char_count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         char_count_ff <= '0;
         hold_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         char_count_ff <= char_count_in;
         hold_ff       <= hold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_byte) begin
         bytes_ff[byte_idx] <= pair_byte;
      end
      if (take && emit) begin
         tag_ff <= tag_word;
         ok_ff  <= (xor_sum == pair_byte);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tag_id      = tag_ff;
   assign rsp_checksum_ok = ok_ff;

   assign status.in_frame   = in_frame_ff;
   assign status.char_count = char_count_ff;
   assign status.emit       = emit;
   assign status.take       = take;

endmodule

`default_nettype wire
